// ----- rtl/qau_pkg.sv -----
// qau_pkg: widths, fixed point constants, operation codes and index tables
// shared by the quaternion arithmetic unit; depends on nothing
package qau_pkg;

    localparam int VALUE_WIDTH   = 24;
    localparam int FRACTION_BITS = 20;

    // product and accumulator widths follow from the value width
    localparam int PROD_WIDTH     = 2 * VALUE_WIDTH;
    localparam int SUM_WIDTH      = PROD_WIDTH + 2;
    localparam int RND_WIDTH      = SUM_WIDTH - FRACTION_BITS;
    localparam int ROT_PROD_WIDTH = RND_WIDTH + VALUE_WIDTH;
    localparam int ROT_SUM_WIDTH  = ROT_PROD_WIDTH + 2;
    localparam int FIN_WIDTH      = ROT_SUM_WIDTH - FRACTION_BITS;

    localparam int NUM_PROD    = 16;
    localparam int NUM_ROT     = 12;
    localparam int NUM_VALUES  = 9;
    localparam int QUAT_VALUES = 4;
    localparam int ROT_VALUES  = 3;
    localparam int MAT_PROD    = 9;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_SCALE,
        OP_ROTATE,
        OP_MATRIX
    } t_op;

    typedef logic signed [VALUE_WIDTH-1:0]    t_val;
    typedef logic signed [PROD_WIDTH-1:0]     t_prod;
    typedef logic signed [SUM_WIDTH-1:0]      t_sum;
    typedef logic signed [RND_WIDTH-1:0]      t_rnd;
    typedef logic signed [ROT_PROD_WIDTH-1:0] t_rp;
    typedef logic signed [ROT_SUM_WIDTH-1:0]  t_rs;
    typedef logic signed [FIN_WIDTH-1:0]      t_fin;

    localparam t_val VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam t_val VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam t_fin FIN_MAX = t_fin'(VAL_MAX);
    localparam t_fin FIN_MIN = t_fin'(VAL_MIN);
    localparam t_fin FIN_ONE = t_fin'(1) <<< FRACTION_BITS;

    localparam t_sum SUM_ONE  = t_sum'(1) <<< (2 * FRACTION_BITS);
    localparam t_sum SUM_HALF = t_sum'(1) <<< (FRACTION_BITS - 1);
    localparam t_rs  RS_HALF  = t_rs'(1) <<< (FRACTION_BITS - 1);

    // matrix products: xx yy zz xy xz yz wx wy wz (component 0..3 = x y z w)
    localparam logic [1:0] MAT_L [MAT_PROD] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd0,
                                                 2'd1, 2'd3, 2'd3, 2'd3};
    localparam logic [1:0] MAT_R [MAT_PROD] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2,
                                                 2'd2, 2'd0, 2'd1, 2'd2};

    // second half of rotate: terms p[l] * a[r], four per output x, y, z,
    // sign folds the hamilton sign with the conjugate of a
    localparam logic [1:0] ROT_L [NUM_ROT] = '{2'd3, 2'd0, 2'd1, 2'd2,
                                               2'd3, 2'd0, 2'd1, 2'd2,
                                               2'd3, 2'd0, 2'd1, 2'd2};
    localparam logic [1:0] ROT_R [NUM_ROT] = '{2'd0, 2'd3, 2'd2, 2'd1,
                                               2'd1, 2'd2, 2'd3, 2'd0,
                                               2'd2, 2'd1, 2'd0, 2'd3};
    localparam logic ROT_NEG [NUM_ROT] = '{1'b1, 1'b0, 1'b1, 1'b0,
                                           1'b1, 1'b0, 1'b0, 1'b1,
                                           1'b1, 1'b1, 1'b0, 1'b0};

endpackage

// ----- rtl/quaternion_arithmetic_unit_core.sv -----
// quaternion unit core: add, subtract, hamilton product, scale, rotate, to matrix
// result strobe: o_valid marks the results held in the output register
// throughput: one request per cycle, busy stays low; six register stages
// (operands, products, sums, round, rotate products, rotate sums) then the output
// reset (synchronous, active low) clears only the valid bits of the pipeline
// depends on qau_pkg
module quaternion_arithmetic_unit_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          i_operation,
    input  qau_pkg::t_val       i_a_x,
    input  qau_pkg::t_val       i_a_y,
    input  qau_pkg::t_val       i_a_z,
    input  qau_pkg::t_val       i_a_w,
    input  qau_pkg::t_val       i_b_x,
    input  qau_pkg::t_val       i_b_y,
    input  qau_pkg::t_val       i_b_z,
    input  qau_pkg::t_val       i_b_w,
    input  qau_pkg::t_val       i_scalar,
    output logic                o_valid,
    output qau_pkg::t_val       o_value_0,
    output qau_pkg::t_val       o_value_1,
    output qau_pkg::t_val       o_value_2,
    output qau_pkg::t_val       o_value_3,
    output qau_pkg::t_val       o_value_4,
    output qau_pkg::t_val       o_value_5,
    output qau_pkg::t_val       o_value_6,
    output qau_pkg::t_val       o_value_7,
    output qau_pkg::t_val       o_value_8,
    output logic                o_saturated
);

    // valid bits for stages 1..6 and the output
    logic [6:1] r_vld;
    logic       r_out_vld;

    // stage 1: operands
    qau_pkg::t_op   r_op1;
    qau_pkg::t_val  r_qa1 [4];
    qau_pkg::t_val  r_qb1 [4];
    qau_pkg::t_val  r_s1;

    // stage 2: products
    qau_pkg::t_op   r_op2;
    qau_pkg::t_val  r_qa2 [4];
    qau_pkg::t_val  r_qb2 [4];
    qau_pkg::t_prod r_prod2 [qau_pkg::NUM_PROD];
    qau_pkg::t_val  n_ma [qau_pkg::NUM_PROD];
    qau_pkg::t_val  n_mb [qau_pkg::NUM_PROD];
    qau_pkg::t_prod n_prod [qau_pkg::NUM_PROD];

    // stage 3: sums at double fraction scale
    qau_pkg::t_op   r_op3;
    qau_pkg::t_val  r_qa3 [4];
    qau_pkg::t_sum  r_sum3 [qau_pkg::NUM_VALUES];
    qau_pkg::t_sum  n_sum [qau_pkg::NUM_VALUES];
    qau_pkg::t_sum  n_two [qau_pkg::MAT_PROD];

    // stage 4: rounded, not yet clamped
    qau_pkg::t_op   r_op4;
    qau_pkg::t_val  r_qa4 [4];
    qau_pkg::t_rnd  r_rnd4 [qau_pkg::NUM_VALUES];
    qau_pkg::t_rnd  n_rnd [qau_pkg::NUM_VALUES];

    // stage 5: products of the first rotate step with conj(a)
    qau_pkg::t_op   r_op5;
    qau_pkg::t_rnd  r_rnd5 [qau_pkg::NUM_VALUES];
    qau_pkg::t_rp   r_rp5 [qau_pkg::NUM_ROT];
    qau_pkg::t_rp   n_rp [qau_pkg::NUM_ROT];

    // stage 6: rotate sums
    qau_pkg::t_op   r_op6;
    qau_pkg::t_rnd  r_rnd6 [qau_pkg::NUM_VALUES];
    qau_pkg::t_rs   r_rs6 [qau_pkg::ROT_VALUES];
    qau_pkg::t_rs   n_rs [qau_pkg::ROT_VALUES];

    // output stage: clamp
    qau_pkg::t_fin  n_pre [qau_pkg::NUM_VALUES];
    logic [3:0]     n_cnt;
    qau_pkg::t_val  n_val [qau_pkg::NUM_VALUES];
    logic           n_sat;
    qau_pkg::t_val  r_val [qau_pkg::NUM_VALUES];
    logic           r_sat;

    // never stalls: a request can enter every cycle
    assign busy = 1'b0;

    // operand select per multiplier slot
    always_comb begin
        for (int k = 0; k < qau_pkg::NUM_PROD; k++) begin
            n_ma[k] = r_qa1[k >> 2];
            n_mb[k] = r_qb1[k & 3];
            // rotate uses (b.xyz, 0) as the right operand
            if (r_op1 == qau_pkg::OP_ROTATE && (k & 3) == 3) begin
                n_mb[k] = '0;
            end
        end
        if (r_op1 == qau_pkg::OP_SCALE) begin
            for (int k = 0; k < qau_pkg::QUAT_VALUES; k++) begin
                n_ma[k] = r_qa1[k];
                n_mb[k] = r_s1;
            end
        end
        if (r_op1 == qau_pkg::OP_MATRIX) begin
            for (int k = 0; k < qau_pkg::MAT_PROD; k++) begin
                n_ma[k] = r_qa1[qau_pkg::MAT_L[k]];
                n_mb[k] = r_qa1[qau_pkg::MAT_R[k]];
            end
        end
        for (int k = 0; k < qau_pkg::NUM_PROD; k++) begin
            n_prod[k] = n_ma[k] * n_mb[k];
        end
    end

    // product sums; slot 4*i+j of the hamilton product is a[i]*b[j]
    always_comb begin
        for (int k = 0; k < qau_pkg::MAT_PROD; k++) begin
            n_two[k] = qau_pkg::t_sum'(r_prod2[k]) <<< 1;
        end
        for (int i = 0; i < qau_pkg::NUM_VALUES; i++) begin
            n_sum[i] = '0;
        end
        case (r_op2)
            qau_pkg::OP_ADD: begin
                for (int i = 0; i < qau_pkg::QUAT_VALUES; i++) begin
                    n_sum[i] = (qau_pkg::t_sum'(r_qa2[i]) + qau_pkg::t_sum'(r_qb2[i]))
                               <<< qau_pkg::FRACTION_BITS;
                end
            end
            qau_pkg::OP_SUB: begin
                for (int i = 0; i < qau_pkg::QUAT_VALUES; i++) begin
                    n_sum[i] = (qau_pkg::t_sum'(r_qa2[i]) - qau_pkg::t_sum'(r_qb2[i]))
                               <<< qau_pkg::FRACTION_BITS;
                end
            end
            qau_pkg::OP_MUL, qau_pkg::OP_ROTATE: begin
                n_sum[0] = qau_pkg::t_sum'(r_prod2[12]) + qau_pkg::t_sum'(r_prod2[3])
                         + qau_pkg::t_sum'(r_prod2[6])  - qau_pkg::t_sum'(r_prod2[9]);
                n_sum[1] = qau_pkg::t_sum'(r_prod2[13]) - qau_pkg::t_sum'(r_prod2[2])
                         + qau_pkg::t_sum'(r_prod2[7])  + qau_pkg::t_sum'(r_prod2[8]);
                n_sum[2] = qau_pkg::t_sum'(r_prod2[14]) + qau_pkg::t_sum'(r_prod2[1])
                         - qau_pkg::t_sum'(r_prod2[4])  + qau_pkg::t_sum'(r_prod2[11]);
                n_sum[3] = qau_pkg::t_sum'(r_prod2[15]) - qau_pkg::t_sum'(r_prod2[0])
                         - qau_pkg::t_sum'(r_prod2[5])  - qau_pkg::t_sum'(r_prod2[10]);
            end
            qau_pkg::OP_SCALE: begin
                for (int i = 0; i < qau_pkg::QUAT_VALUES; i++) begin
                    n_sum[i] = qau_pkg::t_sum'(r_prod2[i]);
                end
            end
            qau_pkg::OP_MATRIX: begin
                // n_two: 2xx 2yy 2zz 2xy 2xz 2yz 2wx 2wy 2wz
                n_sum[0] = qau_pkg::SUM_ONE - n_two[1] - n_two[2];
                n_sum[1] = n_two[3] + n_two[8];
                n_sum[2] = n_two[4] - n_two[7];
                n_sum[3] = n_two[3] - n_two[8];
                n_sum[4] = qau_pkg::SUM_ONE - n_two[0] - n_two[2];
                n_sum[5] = n_two[5] + n_two[6];
                n_sum[6] = n_two[4] + n_two[7];
                n_sum[7] = n_two[5] - n_two[6];
                n_sum[8] = qau_pkg::SUM_ONE - n_two[0] - n_two[1];
            end
            default: begin
            end
        endcase
    end

    // round half up back to the value scale
    always_comb begin
        for (int i = 0; i < qau_pkg::NUM_VALUES; i++) begin
            n_rnd[i] = qau_pkg::t_rnd'((r_sum3[i] + qau_pkg::SUM_HALF)
                                       >>> qau_pkg::FRACTION_BITS);
        end
    end

    // second rotate step: p * conj(a), only x y z are needed
    always_comb begin
        for (int k = 0; k < qau_pkg::NUM_ROT; k++) begin
            n_rp[k] = r_rnd4[qau_pkg::ROT_L[k]] * r_qa4[qau_pkg::ROT_R[k]];
        end
    end

    always_comb begin
        for (int o = 0; o < qau_pkg::ROT_VALUES; o++) begin
            n_rs[o] = '0;
            for (int j = 0; j < 4; j++) begin
                if (qau_pkg::ROT_NEG[4*o+j]) begin
                    n_rs[o] = n_rs[o] - qau_pkg::t_rs'(r_rp5[4*o+j]);
                end else begin
                    n_rs[o] = n_rs[o] + qau_pkg::t_rs'(r_rp5[4*o+j]);
                end
            end
        end
    end

    // final value select and clamp
    always_comb begin
        for (int i = 0; i < qau_pkg::NUM_VALUES; i++) begin
            n_pre[i] = qau_pkg::t_fin'(r_rnd6[i]);
        end
        if (r_op6 == qau_pkg::OP_ROTATE) begin
            for (int o = 0; o < qau_pkg::ROT_VALUES; o++) begin
                n_pre[o] = qau_pkg::t_fin'((r_rs6[o] + qau_pkg::RS_HALF)
                                           >>> qau_pkg::FRACTION_BITS);
            end
            n_pre[3] = qau_pkg::FIN_ONE;
        end
        case (r_op6)
            qau_pkg::OP_ADD, qau_pkg::OP_SUB, qau_pkg::OP_MUL,
            qau_pkg::OP_SCALE, qau_pkg::OP_ROTATE: n_cnt = 4'(qau_pkg::QUAT_VALUES);
            qau_pkg::OP_MATRIX:                     n_cnt = 4'(qau_pkg::NUM_VALUES);
            default:                                n_cnt = '0;
        endcase
        n_sat = 1'b0;
        for (int i = 0; i < qau_pkg::NUM_VALUES; i++) begin
            n_val[i] = '0;
            if (4'(i) < n_cnt) begin
                if (n_pre[i] > qau_pkg::FIN_MAX) begin
                    n_val[i] = qau_pkg::VAL_MAX;
                    n_sat    = 1'b1;
                end else if (n_pre[i] < qau_pkg::FIN_MIN) begin
                    n_val[i] = qau_pkg::VAL_MIN;
                    n_sat    = 1'b1;
                end else begin
                    n_val[i] = qau_pkg::t_val'(n_pre[i]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[5:1], start & ~busy};
            r_out_vld <= r_vld[6];
        end
    end

    always_ff @(posedge i_clk) begin
        r_op1    <= qau_pkg::t_op'(i_operation);
        r_qa1[0] <= i_a_x;
        r_qa1[1] <= i_a_y;
        r_qa1[2] <= i_a_z;
        r_qa1[3] <= i_a_w;
        r_qb1[0] <= i_b_x;
        r_qb1[1] <= i_b_y;
        r_qb1[2] <= i_b_z;
        r_qb1[3] <= i_b_w;
        r_s1     <= i_scalar;

        r_op2   <= r_op1;
        r_qa2   <= r_qa1;
        r_qb2   <= r_qb1;
        r_prod2 <= n_prod;

        r_op3  <= r_op2;
        r_qa3  <= r_qa2;
        r_sum3 <= n_sum;

        r_op4  <= r_op3;
        r_qa4  <= r_qa3;
        r_rnd4 <= n_rnd;

        r_op5  <= r_op4;
        r_rnd5 <= r_rnd4;
        r_rp5  <= n_rp;

        r_op6  <= r_op5;
        r_rnd6 <= r_rnd5;
        r_rs6  <= n_rs;

        r_val <= n_val;
        r_sat <= n_sat;
    end

    assign o_valid     = r_out_vld;
    assign o_value_0   = r_val[0];
    assign o_value_1   = r_val[1];
    assign o_value_2   = r_val[2];
    assign o_value_3   = r_val[3];
    assign o_value_4   = r_val[4];
    assign o_value_5   = r_val[5];
    assign o_value_6   = r_val[6];
    assign o_value_7   = r_val[7];
    assign o_value_8   = r_val[8];
    assign o_saturated = r_sat;

    // every accepted request must produce a result strobe from the output register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##7 o_valid)
        else $error("result strobe missing seven edges after request");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 7))
        else $error("result strobe without a matching request");

    // unknown operation codes give zero and no clamp
    a_unknown_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_operation, 7) > qau_pkg::OP_MATRIX
        |-> !o_saturated && o_value_0 == '0 && o_value_3 == '0)
        else $error("unknown operation produced a nonzero result");

    // matrix entries beyond the quaternion stay zero for other operations
    a_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_operation, 7) != qau_pkg::OP_MATRIX
        |-> o_value_4 == '0 && o_value_8 == '0)
        else $error("upper result values nonzero outside matrix operation");

endmodule
